### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for concurrent assertions clocked on clk and reset by rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

### rtl/stsq_pkg.sv
// ----------------------------------------------------------------------------
// Speed teach sequencer package
// Widths, phase codes, controller states and the command and status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package stsq_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned ENG_W   = 29;
  localparam int unsigned PHASE_W = 4;

  // Engine counts are scaled down by this divisor when a window ends.
  localparam logic [DATA_W-1:0] ENGINE_DIV = 32'd10;

  // Division by ten as a multiplication by ceil(2^35 / 10) followed by a
  // 35-bit right shift, which is exact for every 32-bit count.
  localparam logic [DATA_W-1:0] ENG_RECIP = 32'hCCCC_CCCD;
  localparam int unsigned       ENG_SHIFT = 35;

  typedef enum logic [PHASE_W-1:0] {
    PH_PREP       = 4'd0,
    PH_WAIT_SLOW  = 4'd1,
    PH_SLOW_TIME  = 4'd2,
    PH_SLOW_CONF  = 4'd3,
    PH_WAIT_FAST  = 4'd4,
    PH_FAST_TIME  = 4'd5,
    PH_FAST_CONF  = 4'd6,
    PH_END        = 4'd7,
    PH_WAIT_RESET = 4'd8
  } phase_t;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_DECODE,
    CS_DIV_ENG,
    CS_DIV_GAP,
    CS_APPLY,
    CS_PUBLISH
  } ctrl_state_t;

  typedef struct packed {
    logic     capture;
    logic     div_start;
    logic     store_eng;
    logic     store_gap;
    logic     apply;
    logic     publish;
  } stsq_cmd_t;

  typedef struct packed {
    logic needs_div;
    logic count_zero;
    logic div_done;
    logic out_free;
  } stsq_status_t;

endpackage

`default_nettype wire

### rtl/stsq_if.sv
// ----------------------------------------------------------------------------
// Speed teach sequencer channels
// Valid/ready channels for input items and for result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface stsq_in_if import stsq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              action;
  logic              teach_slow_req;
  logic              teach_fast_req;
  logic              end_teach_req;
  logic              target_reached;
  logic              window_done;
  logic [DATA_W-1:0] engine_measure;
  logic              sensor_id;
  logic [DATA_W-1:0] edge_time_ms;

  modport source (
    output valid, action, teach_slow_req, teach_fast_req, end_teach_req,
           target_reached, window_done, engine_measure, sensor_id, edge_time_ms,
    input  ready
  );
  modport sink (
    input  valid, action, teach_slow_req, teach_fast_req, end_teach_req,
           target_reached, window_done, engine_measure, sensor_id, edge_time_ms,
    output ready
  );
endinterface

interface stsq_out_if import stsq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PHASE_W-1:0] phase;
  logic               speed_ready;
  logic               window_start;
  logic               save_pulse;
  logic [ENG_W-1:0]   slow_engine_time;
  logic [ENG_W-1:0]   fast_engine_time;
  logic [DATA_W-1:0]  slow_step_time;
  logic [DATA_W-1:0]  fast_step_time;

  modport source (
    output valid, phase, speed_ready, window_start, save_pulse, slow_engine_time,
           fast_engine_time, slow_step_time, fast_step_time,
    input  ready
  );
  modport sink (
    input  valid, phase, speed_ready, window_start, save_pulse, slow_engine_time,
           fast_engine_time, slow_step_time, fast_step_time,
    output ready
  );
endinterface

`default_nettype wire

### rtl/speed_teach_sequencer.sv
// Speed teach sequencer: takes control ticks and step sensor edges one item at a
// time and returns one result item per input item, carrying the phase, the speed
// ready level, the window start and save pulses and the four taught values. An
// ordinary item passes through the decode, apply and publish states, its result
// being registered when it is published. A tick that ends a measurement window
// also scales the engine count down by ten with a reciprocal multiplication and,
// when any steps were counted, runs the 32-bit restoring divider for the mean step
// gap before the apply state. A new item is taken while the previous result still
// waits in the output register; the next result then holds the controller until
// the output register is free.
// ----------------------------------------------------------------------------
// Speed teach sequencer top level
// Joins the controller and the datapath to the item and result channels.
// ----------------------------------------------------------------------------
`default_nettype none

module speed_teach_sequencer import stsq_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  stsq_in_if.sink     item_in,
  stsq_out_if.source  result_out
);

  stsq_cmd_t    cmd;
  stsq_status_t status;
  logic         in_ready;
  logic         out_valid;

  assign item_in.ready    = in_ready;
  assign result_out.valid = out_valid;

  stsq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item_in.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  stsq_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .action           (item_in.action),
    .teach_slow_req   (item_in.teach_slow_req),
    .teach_fast_req   (item_in.teach_fast_req),
    .end_teach_req    (item_in.end_teach_req),
    .target_reached   (item_in.target_reached),
    .window_done      (item_in.window_done),
    .engine_measure   (item_in.engine_measure),
    .sensor_id        (item_in.sensor_id),
    .edge_time_ms     (item_in.edge_time_ms),
    .out_ready        (result_out.ready),
    .out_valid        (out_valid),
    .phase            (result_out.phase),
    .speed_ready      (result_out.speed_ready),
    .window_start     (result_out.window_start),
    .save_pulse       (result_out.save_pulse),
    .slow_engine_time (result_out.slow_engine_time),
    .fast_engine_time (result_out.fast_engine_time),
    .slow_step_time   (result_out.slow_step_time),
    .fast_step_time   (result_out.fast_step_time)
  );

endmodule

`default_nettype wire

### rtl/stsq_div.sv
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring unsigned divider, one quotient bit per cycle; done pulses once.
// ----------------------------------------------------------------------------
`default_nettype none

module stsq_div import stsq_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [DATA_W-1:0] dividend,
  input  wire logic [DATA_W-1:0] divisor,
  output logic                   done,
  output logic [DATA_W-1:0]      quotient
);

  localparam int unsigned CNT_W = $clog2(DATA_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_W - 1);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] quo;
  logic [DATA_W-1:0] dsr;
  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   trial;
  logic              fits;

  // One trial subtraction per cycle.
  always_comb begin
    shifted = {rem, quo[DATA_W-1]};
    trial   = shifted - {1'b0, dsr};
    fits    = ~trial[DATA_W];
  end

  // Sequencing of the iterations.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Partial remainder and quotient.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= fits ? trial[DATA_W-1:0] : shifted[DATA_W-1:0];
      quo <= {quo[DATA_W-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

`default_nettype wire

### rtl/stsq_ctrl.sv
// ----------------------------------------------------------------------------
// Speed teach sequencer controller
// Steps each item through decode, the window-end scaling and division, update
// and output.
// ----------------------------------------------------------------------------
`default_nettype none

module stsq_ctrl import stsq_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire stsq_status_t status,
  output stsq_cmd_t         cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      CS_IDLE: begin
        if (in_valid) state_next = CS_DECODE;
      end
      CS_DECODE: begin
        state_next = status.needs_div ? CS_DIV_ENG : CS_APPLY;
      end
      CS_DIV_ENG: begin
        state_next = status.count_zero ? CS_APPLY : CS_DIV_GAP;
      end
      CS_DIV_GAP: begin
        if (status.div_done) state_next = CS_APPLY;
      end
      CS_APPLY: begin
        state_next = CS_PUBLISH;
      end
      CS_PUBLISH: begin
        if (status.out_free) state_next = CS_IDLE;
      end
      default: begin
        state_next = CS_IDLE;
      end
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    in_ready      = (state == CS_IDLE);
    cmd.capture   = (state == CS_IDLE) && in_valid;
    cmd.div_start = (state == CS_DIV_ENG) && !status.count_zero;
    cmd.store_eng = (state == CS_DIV_ENG);
    cmd.store_gap = (state == CS_DIV_GAP) && status.div_done;
    cmd.apply     = (state == CS_APPLY);
    cmd.publish   = (state == CS_PUBLISH) && status.out_free;
  end

endmodule

`default_nettype wire

### rtl/stsq_dp.sv
// ----------------------------------------------------------------------------
// Speed teach sequencer datapath
// Item register, teach state, step gap sums, taught values and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module stsq_dp import stsq_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire stsq_cmd_t         cmd,
  output stsq_status_t           status,
  // Input item
  input  wire logic              action,
  input  wire logic              teach_slow_req,
  input  wire logic              teach_fast_req,
  input  wire logic              end_teach_req,
  input  wire logic              target_reached,
  input  wire logic              window_done,
  input  wire logic [DATA_W-1:0] engine_measure,
  input  wire logic              sensor_id,
  input  wire logic [DATA_W-1:0] edge_time_ms,
  // Result item
  input  wire logic              out_ready,
  output logic                   out_valid,
  output logic [PHASE_W-1:0]     phase,
  output logic                   speed_ready,
  output logic                   window_start,
  output logic                   save_pulse,
  output logic [ENG_W-1:0]       slow_engine_time,
  output logic [ENG_W-1:0]       fast_engine_time,
  output logic [DATA_W-1:0]      slow_step_time,
  output logic [DATA_W-1:0]      fast_step_time
);

  // Captured item.
  logic              item_action;
  logic              item_slow;
  logic              item_fast;
  logic              item_end;
  logic              item_reached;
  logic              item_done;
  logic [DATA_W-1:0] item_engine;
  logic              item_sensor;
  logic [DATA_W-1:0] item_time;

  // Teach state.
  phase_t            teach_phase;
  logic              first_seen;
  logic              second_seen;
  logic [DATA_W-1:0] edge_stamp;
  logic [DATA_W-1:0] gap_sum;
  logic [DATA_W-1:0] step_count;
  logic              ready_level;
  logic              win_pend;
  logic              save_pend;
  logic [ENG_W-1:0]  slow_eng;
  logic [ENG_W-1:0]  fast_eng;
  logic [DATA_W-1:0] slow_step;
  logic [DATA_W-1:0] fast_step;

  phase_t            teach_phase_next;
  logic              first_seen_next;
  logic              second_seen_next;
  logic [DATA_W-1:0] edge_stamp_next;
  logic [DATA_W-1:0] gap_sum_next;
  logic [DATA_W-1:0] step_count_next;
  logic              ready_level_next;
  logic              win_pend_next;
  logic              save_pend_next;

  logic              in_timing;
  logic              fast_window;
  logic [2*DATA_W-1:0] eng_prod;
  logic [ENG_W-1:0]  eng_quot;
  logic              div_done;
  logic [DATA_W-1:0] div_quotient;

  // Item register.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_action  <= action;
      item_slow    <= teach_slow_req;
      item_fast    <= teach_fast_req;
      item_end     <= end_teach_req;
      item_reached <= target_reached;
      item_done    <= window_done;
      item_engine  <= engine_measure;
      item_sensor  <= sensor_id;
      item_time    <= edge_time_ms;
    end
  end

  assign in_timing   = (teach_phase == PH_SLOW_TIME) || (teach_phase == PH_FAST_TIME);
  assign fast_window = (teach_phase == PH_FAST_TIME);

  // Engine count over ten: a 32 by 32 product with the reciprocal, top bits kept.
  assign eng_prod = {{DATA_W{1'b0}}, item_engine} * {{DATA_W{1'b0}}, ENG_RECIP};
  assign eng_quot = eng_prod[ENG_SHIFT +: ENG_W];

  // Divider for the mean step gap.
  stsq_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (gap_sum),
    .divisor  (step_count),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // Status back to the controller.
  always_comb begin
    status.needs_div  = !item_action && item_done && in_timing;
    status.count_zero = (step_count == '0);
    status.div_done   = div_done;
    status.out_free   = !out_valid || out_ready;
  end

  // State update for one item.
  always_comb begin
    teach_phase_next = teach_phase;
    first_seen_next  = first_seen;
    second_seen_next = second_seen;
    edge_stamp_next  = edge_stamp;
    gap_sum_next     = gap_sum;
    step_count_next  = step_count;
    ready_level_next = ready_level;
    win_pend_next    = 1'b0;
    save_pend_next   = 1'b0;
    if (item_action) begin
      // Sensor edges pair up only while a window is timing.
      if (in_timing) begin
        if (item_sensor ? first_seen : second_seen) begin
          if (item_sensor) begin
            first_seen_next = 1'b0;
          end else begin
            second_seen_next = 1'b0;
          end
          gap_sum_next    = gap_sum + (item_time - edge_stamp);
          edge_stamp_next = '0;
        end else begin
          edge_stamp_next = item_time;
          step_count_next = step_count + 1'b1;
          if (item_sensor) begin
            second_seen_next = 1'b1;
          end else begin
            first_seen_next = 1'b1;
          end
        end
      end
    end else begin
      unique case (teach_phase)
        PH_PREP: begin
          if (item_slow) teach_phase_next = PH_WAIT_SLOW;
        end
        PH_WAIT_SLOW, PH_WAIT_FAST: begin
          if (item_reached) begin
            ready_level_next = 1'b1;
            win_pend_next    = 1'b1;
            teach_phase_next = (teach_phase == PH_WAIT_SLOW) ? PH_SLOW_TIME : PH_FAST_TIME;
          end
        end
        PH_SLOW_TIME, PH_FAST_TIME: begin
          if (item_done) begin
            gap_sum_next     = '0;
            step_count_next  = '0;
            ready_level_next = 1'b0;
            teach_phase_next = fast_window ? PH_FAST_CONF : PH_SLOW_CONF;
          end
        end
        PH_SLOW_CONF: begin
          if (item_fast) begin
            teach_phase_next = PH_WAIT_FAST;
          end else if (item_slow) begin
            teach_phase_next = PH_WAIT_SLOW;
          end
        end
        PH_FAST_CONF: begin
          if (item_fast) begin
            teach_phase_next = PH_WAIT_FAST;
          end else if (item_end) begin
            teach_phase_next = PH_END;
          end
        end
        PH_END: begin
          save_pend_next   = 1'b1;
          teach_phase_next = PH_WAIT_RESET;
        end
        default: begin
          teach_phase_next = teach_phase;
        end
      endcase
    end
  end

  // Teach state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      teach_phase <= PH_PREP;
      first_seen  <= 1'b0;
      second_seen <= 1'b0;
      edge_stamp  <= '0;
      gap_sum     <= '0;
      step_count  <= '0;
      ready_level <= 1'b0;
      win_pend    <= 1'b0;
      save_pend   <= 1'b0;
    end else if (cmd.apply) begin
      teach_phase <= teach_phase_next;
      first_seen  <= first_seen_next;
      second_seen <= second_seen_next;
      edge_stamp  <= edge_stamp_next;
      gap_sum     <= gap_sum_next;
      step_count  <= step_count_next;
      ready_level <= ready_level_next;
      win_pend    <= win_pend_next;
      save_pend   <= save_pend_next;
    end
  end

  // Taught values, written as the window-end results become available.
  always_ff @(posedge clk) begin
    if (rst) begin
      slow_eng  <= '0;
      fast_eng  <= '0;
      slow_step <= '0;
      fast_step <= '0;
    end else begin
      if (cmd.store_eng) begin
        if (fast_window) begin
          fast_eng <= eng_quot;
        end else begin
          slow_eng <= eng_quot;
        end
      end
      if (cmd.store_gap) begin
        if (fast_window) begin
          fast_step <= div_quotient;
        end else begin
          slow_step <= div_quotient;
        end
      end
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      phase            <= teach_phase;
      speed_ready      <= ready_level;
      window_start     <= win_pend;
      save_pulse       <= save_pend;
      slow_engine_time <= slow_eng;
      fast_engine_time <= fast_eng;
      slow_step_time   <= slow_step;
      fast_step_time   <= fast_step;
    end
  end

endmodule

`default_nettype wire

### rtl/stsq_checker.sv
// ----------------------------------------------------------------------------
// Speed teach sequencer checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module stsq_port_checks import stsq_pkg::*; (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [PHASE_W-1:0] phase,
  input wire logic               speed_ready,
  input wire logic               window_start,
  input wire logic               save_pulse
);

  // A window start item always shows the speed ready level raised.
  `ASSERT_SAME(a_start_ready, out_valid && window_start, speed_ready)

  // The save pulse comes only on the move into wait reset, with speed ready low.
  `ASSERT_SAME(a_save_phase, out_valid && save_pulse, (phase == PH_WAIT_RESET) && !speed_ready)

  // The two pulses never come in the same item.
  `ASSERT_SAME(a_pulse_excl, out_valid, !(window_start && save_pulse))

  // A result item that is not taken stays offered.
  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

endmodule

bind speed_teach_sequencer stsq_port_checks u_stsq_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (result_out.valid),
  .out_ready    (result_out.ready),
  .phase        (result_out.phase),
  .speed_ready  (result_out.speed_ready),
  .window_start (result_out.window_start),
  .save_pulse   (result_out.save_pulse)
);

`default_nettype wire
